### sv/csvfs_pkg.sv
// shared constants and types of the csv field splitter
package csvfs_pkg;

  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_CELL_END = 2'd1,
    KIND_ROW_END  = 2'd2
  } kind_t;

endpackage

### sv/csv_field_splitter_core.sv
// csv field splitter: turns csv text bytes into cell bytes and cell and row end markers
//
// Each input transaction carries one text byte (operation 0) or an end-of-text mark
// (operation 1) and yields zero or one result transaction. The block takes one input
// transaction per clock while in_ready is high: a transaction lands in an input register,
// is decoded against the five parser flags once the output register can take a result,
// and its result, if any, is then registered in the output register, so the sustained
// rate is one item per cycle while out_ready stays high. Input and output are parted by those
// two registers; in_ready drops only when the input register is full and the output register
// holds a result that is not being taken. Blank lines, the LF of a CRLF pair and quote
// bytes that only open or close quoting produce no result. End of text closes an open row
// with one row-end result and returns the parser to its reset state.
module csv_field_splitter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_cell_byte
);
  import csvfs_pkg::*;

  logic       s1_valid_r;
  logic       s1_op_r;
  logic [7:0] s1_byte_r;

  logic row_open_r, row_open_nxt;
  logic cell_fresh_r, cell_fresh_nxt;
  logic in_quotes_r, in_quotes_nxt;
  logic quote_pending_r, quote_pending_nxt;
  logic after_cr_r, after_cr_nxt;

  logic       out_valid_r;
  kind_t      out_kind_r;
  logic [7:0] out_byte_r;

  logic       advance;
  logic       unquoted;
  logic       res_vld;
  kind_t      res_kind;
  logic [7:0] res_byte;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    row_open_nxt      = row_open_r;
    cell_fresh_nxt    = cell_fresh_r;
    in_quotes_nxt     = in_quotes_r;
    quote_pending_nxt = quote_pending_r;
    after_cr_nxt      = after_cr_r;
    res_vld           = 1'b0;
    res_kind          = KIND_DATA;
    res_byte          = '0;
    unquoted          = 1'b0;
    if (s1_valid_r && advance) begin
      if (s1_op_r == OP_END) begin
        row_open_nxt      = 1'b0;
        cell_fresh_nxt    = 1'b1;
        in_quotes_nxt     = 1'b0;
        quote_pending_nxt = 1'b0;
        after_cr_nxt      = 1'b0;
        res_vld           = row_open_r;
        res_kind          = KIND_ROW_END;
      end else begin
        after_cr_nxt = 1'b0;
        if (after_cr_r && s1_byte_r == CHR_LF) begin
          unquoted = 1'b0;
        end else if (in_quotes_r) begin
          if (quote_pending_r) begin
            quote_pending_nxt = 1'b0;
            if (s1_byte_r == CHR_QUOTE) begin
              res_vld  = 1'b1;
              res_byte = CHR_QUOTE;
            end else begin
              in_quotes_nxt = 1'b0;
              unquoted      = 1'b1;
            end
          end else if (s1_byte_r == CHR_QUOTE) begin
            quote_pending_nxt = 1'b1;
          end else begin
            res_vld  = 1'b1;
            res_byte = s1_byte_r;
          end
        end else begin
          unquoted = 1'b1;
        end

        if (unquoted) begin
          if (s1_byte_r == CHR_CR || s1_byte_r == CHR_LF) begin
            after_cr_nxt   = (s1_byte_r == CHR_CR);
            row_open_nxt   = 1'b0;
            cell_fresh_nxt = 1'b1;
            res_vld        = row_open_r;
            res_kind       = KIND_ROW_END;
          end else if (s1_byte_r == CHR_COMMA) begin
            row_open_nxt   = 1'b1;
            cell_fresh_nxt = 1'b1;
            res_vld        = 1'b1;
            res_kind       = KIND_CELL_END;
          end else if (s1_byte_r == CHR_QUOTE && cell_fresh_r) begin
            row_open_nxt   = 1'b1;
            cell_fresh_nxt = 1'b0;
            in_quotes_nxt  = 1'b1;
          end else begin
            row_open_nxt   = 1'b1;
            cell_fresh_nxt = 1'b0;
            res_vld        = 1'b1;
            res_byte       = s1_byte_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      row_open_r      <= 1'b0;
      cell_fresh_r    <= 1'b1;
      in_quotes_r     <= 1'b0;
      quote_pending_r <= 1'b0;
      after_cr_r      <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= res_vld;
      end
      row_open_r      <= row_open_nxt;
      cell_fresh_r    <= cell_fresh_nxt;
      in_quotes_r     <= in_quotes_nxt;
      quote_pending_r <= quote_pending_nxt;
      after_cr_r      <= after_cr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r   <= in_operation;
      s1_byte_r <= in_text_byte;
    end
    if (advance) begin
      out_kind_r <= res_kind;
      out_byte_r <= res_byte;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_cell_byte = out_byte_r;

endmodule

### sv/csvfs_checker.sv
// port-level checks of the csv field splitter and their bind
module csvfs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_cell_byte
);
  import csvfs_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_cell_byte))
    else $error("stalled result changed");

  // markers carry a zero byte
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_cell_byte == 8'd0)
    else $error("marker with nonzero byte");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind == KIND_DATA || out_kind == KIND_CELL_END ||
                  out_kind == KIND_ROW_END)
    else $error("bad result kind");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // free output side never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while output is free");

endmodule

bind csv_field_splitter_core csvfs_checker u_csvfs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_kind      (out_kind),
  .out_cell_byte (out_cell_byte)
);
